// File: src/ttrt_pkg.sv
// Shared types, constants and helpers for the timestamp trap rate table.
// Used by the front end, back end and top level; depends on nothing.
package ttrt_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [1:0] LEVEL_USER      = 2'h3;
	localparam logic [7:0] OP_ESCAPE       = 8'h0F;
	localparam logic [7:0] OP_RDTSC        = 8'h31;
	localparam logic [7:0] OP_GROUP7       = 8'h01;
	localparam logic [7:0] OP_RDTSCP_MODRM = 8'hF9;

	localparam logic [1:0] ADV_NONE   = 2'd0;
	localparam logic [1:0] ADV_RDTSC  = 2'd2;
	localparam logic [1:0] ADV_RDTSCP = 2'd3;

	// APB register map
	localparam int         PADDR_W            = 3;
	localparam logic       REG_RATE_THRESHOLD = 1'b0;
	localparam logic [31:0] RATE_THRESHOLD_RST = 32'd1000;

	typedef struct packed {
		logic [1:0]  privilege_level;
		logic        fetch_ok;
		logic [7:0]  instr_byte0;
		logic [7:0]  instr_byte1;
		logic [7:0]  instr_byte2;
		logic [31:0] process_id;
		logic [63:0] timestamp;
		logic [31:0] aux_value;
	} in_t;

	typedef struct packed {
		logic        handled;
		logic        is_rdtscp;
		logic [31:0] high_half;
		logic [31:0] low_half;
		logic [31:0] aux_out;
		logic [1:0]  pc_advance;
		logic [31:0] event_count;
		logic        newly_flagged;
		logic        table_full;
		logic [31:0] flagged_id;
	} out_t;

	// classified fault as it waits between front and back
	typedef struct packed {
		logic        handled;
		logic        is_rdtscp;
		logic [31:0] process_id;
		logic [63:0] timestamp;
		logic [31:0] aux_value;
	} item_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] count;
		logic        flag;
	} entry_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == '1) ? v : v + 32'd1;
	endfunction

endpackage

// File: src/ttrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/ttrt_front.sv
// Front end: accepts faults, decodes RDTSC/RDTSCP, queues classified items.
// Depends on ttrt_pkg.
module ttrt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ttrt_pkg::in_t   item,
	output logic            busy,
	output ttrt_pkg::item_t head,
	output logic            head_valid,
	input  logic            pop
);
	import ttrt_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	item_t            cls;
	logic             plain;
	logic             withaux;
	logic             push;
	logic             do_pop;

	always_comb begin
		plain   = (item.instr_byte0 == OP_ESCAPE) && (item.instr_byte1 == OP_RDTSC);
		withaux = (item.instr_byte0 == OP_ESCAPE) && (item.instr_byte1 == OP_GROUP7)
		       && (item.instr_byte2 == OP_RDTSCP_MODRM);
		cls.handled    = (item.privilege_level == LEVEL_USER) && item.fetch_ok
		              && (plain || withaux);
		cls.is_rdtscp  = withaux;
		cls.process_id = item.process_id;
		cls.timestamp  = item.timestamp;
		cls.aux_value  = item.aux_value;
	end

	assign busy       = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign push       = start && !busy;
	assign head_valid = (fill_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: src/ttrt_back.sv
// Back end: walks the process table for each queued item that needs it and emits the result.
// Depends on ttrt_pkg and ttrt_ram.
module ttrt_back #(
	parameter int TABLE_ENTRIES = ttrt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ttrt_pkg::item_t head,
	input  logic            head_valid,
	output logic            pop,
	input  logic [31:0]     rate_threshold,
	output ttrt_pkg::out_t  result,
	output logic            done
);
	import ttrt_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int ENT_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_CMP  = 3'b100
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	// entries below fill_q hold claimed ids; entry fill_q is the free head
	logic [CNT_W-1:0] fill_q;
	logic [31:0]      free_cnt_q;
	logic             free_flag_q;
	logic [31:0]      last_flagged_q;
	out_t             result_q;
	logic             done_q;

	entry_t           rdata;
	logic [ENT_W-1:0] rdata_raw;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;

	logic             act_none, act_full, act_claim, act_match_mem, act_match_free;
	logic             finish;
	logic             is_full;
	logic [31:0]      base_cnt;
	logic             base_flag;
	logic [31:0]      new_cnt;
	logic             fresh;
	out_t             res;

	assign is_full = (fill_q == CNT_W'(TABLE_ENTRIES));
	assign rdata   = entry_t'(rdata_raw);

	ttrt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rdata_raw)
	);

	// walk control
	always_comb begin
		state_d        = state_q;
		idx_d          = idx_q;
		act_none       = 1'b0;
		act_full       = 1'b0;
		act_claim      = 1'b0;
		act_match_mem  = 1'b0;
		act_match_free = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					priority if (!head.handled) begin
						act_none = 1'b1;
					end else if (head.process_id == '0) begin
						act_full       = is_full;
						act_match_free = !is_full;
					end else if (fill_q == '0) begin
						act_claim = 1'b1;
					end else begin
						idx_d   = '0;
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				priority if (rdata.id == head.process_id) begin
					act_match_mem = 1'b1;
					state_d       = ST_IDLE;
				end else if ((idx_q + CNT_W'(1)) == fill_q) begin
					act_full  = is_full;
					act_claim = !is_full;
					state_d   = ST_IDLE;
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign finish = act_none || act_full || act_claim || act_match_mem || act_match_free;
	assign pop    = finish;

	// count update for a match, either in the table or on the free head
	always_comb begin
		base_cnt  = act_match_mem ? rdata.count : free_cnt_q;
		base_flag = act_match_mem ? rdata.flag : free_flag_q;
		new_cnt   = sat_inc(base_cnt);
		fresh     = (act_match_mem || act_match_free) && (new_cnt > rate_threshold)
		         && !base_flag;
	end

	always_comb begin
		mem_we    = act_claim || act_match_mem;
		mem_waddr = act_claim ? fill_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
		mem_wdata.id    = head.process_id;
		mem_wdata.count = act_claim ? 32'd1 : new_cnt;
		mem_wdata.flag  = act_claim ? free_flag_q : (base_flag || fresh);
	end

	always_comb begin
		res.handled       = head.handled;
		res.is_rdtscp     = head.handled && head.is_rdtscp;
		res.high_half     = head.handled ? head.timestamp[63:32] : 32'd0;
		res.low_half      = head.handled ? head.timestamp[31:0] : 32'd0;
		res.aux_out       = (head.handled && head.is_rdtscp) ? head.aux_value : 32'd0;
		res.pc_advance    = !head.handled ? ADV_NONE
		                  : (head.is_rdtscp ? ADV_RDTSCP : ADV_RDTSC);
		res.event_count   = act_claim ? 32'd1
		                  : ((act_match_mem || act_match_free) ? new_cnt : 32'd0);
		res.newly_flagged = fresh;
		res.table_full    = act_full;
		res.flagged_id    = fresh ? head.process_id : last_flagged_q;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			fill_q         <= '0;
			free_cnt_q     <= '0;
			free_flag_q    <= 1'b0;
			last_flagged_q <= '0;
			done_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			done_q  <= finish;
			if (fresh) begin
				last_flagged_q <= head.process_id;
			end
			if (act_claim) begin
				// advance the free head; the next free entry is untouched
				fill_q      <= fill_q + CNT_W'(1);
				free_cnt_q  <= '0;
				free_flag_q <= 1'b0;
			end else if (act_match_free) begin
				free_cnt_q  <= new_cnt;
				free_flag_q <= free_flag_q || fresh;
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

// File: src/timestamp_trap_rate_table_core.sv
// Top level of the timestamp trap rate table: APB register, front end, back end.
// Depends on ttrt_pkg, ttrt_front, ttrt_back (and ttrt_ram below it).
//
// A fault is taken when start is high and busy is low; the queue holds two
// decoded faults, the one the back end is working on included. A fault that is
// not a user-level RDTSC/RDTSCP, has process id zero, or meets an empty table
// is finished by the back end straight from idle; otherwise the back end
// leaves idle and scans the table in entry order, each entry going through a
// registered RAM read and then a compare. The number of entries compared is
// the matching entry's position plus one, or the number of claimed entries
// when it claims the next free one or meets a full table, at most TABLE_ENTRIES.
// The result appears on result with done high for exactly one cycle, the cycle
// after the back end finishes; it must be taken then, the block cannot be
// stalled. No clearing pass is needed after reset.
module timestamp_trap_rate_table_core #(
	parameter int TABLE_ENTRIES = ttrt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  ttrt_pkg::in_t                  item,
	output logic                           done,
	output ttrt_pkg::out_t                 result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ttrt_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import ttrt_pkg::*;

	logic [31:0] rate_threshold_q;
	item_t       head;
	logic        head_valid;
	logic        pop;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == REG_RATE_THRESHOLD);
	assign prdata  = reg_sel ? rate_threshold_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_threshold_q <= RATE_THRESHOLD_RST;
		end else if (psel && penable && pwrite && reg_sel) begin
			rate_threshold_q <= pwdata;
		end
	end

	ttrt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.busy       (busy),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	ttrt_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.head_valid     (head_valid),
		.pop            (pop),
		.rate_threshold (rate_threshold_q),
		.result         (result),
		.done           (done)
	);

endmodule
